### rtl/core/esg_pkg.sv
`timescale 1ns / 1ps
// Shared widths for the ellipse span generator core.
// Used by the bit-serial multiplier, square root and divider units and by the top level.
package esg_pkg;

    localparam int CX_W   = 7;
    localparam int CY_W   = 6;
    localparam int RX_W   = 6;
    localparam int RY_W   = 5;
    localparam int DY_W   = RY_W + 1;
    localparam int HW_W   = RX_W;
    localparam int XY_W   = 8;
    localparam int LEN_W  = 7;

    localparam int MUL_A_W = 2 * RX_W;
    localparam int MUL_B_W = 2 * RY_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ROOT_W  = PROD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = 4;

endpackage

### rtl/core/esg_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on esg_pkg for operand and product widths.
module esg_mul
    import esg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_product
);

    logic [PROD_W-1:0]  r_a, n_a;
    logic [MUL_B_W-1:0] r_b, n_b;
    logic [PROD_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a    = PROD_W'(i_a);
            n_b    = i_b;
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[PROD_W-2:0], 1'b0};
            n_b   = {1'b0, r_b[MUL_B_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

### rtl/core/esg_sqrt.sv
`timescale 1ns / 1ps
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// Depends on esg_pkg for radicand, root and remainder widths.
module esg_sqrt
    import esg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [PROD_W-1:0] r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[PROD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root[ROOT_W-2:0], 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad  = {r_rad[PROD_W-3:0], 2'b00};
            n_rem  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            n_root = {r_root[ROOT_W-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/esg_div.sv
`timescale 1ns / 1ps
// Restoring divider of the root by the vertical radius, one quotient bit per cycle.
// Depends on esg_pkg for dividend and divisor widths.
module esg_div
    import esg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ROOT_W-1:0] i_dividend,
    input  logic [RY_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_quotient
);

    logic [ROOT_W-1:0] r_q, n_q;
    logic [RY_W-1:0]   r_rem, n_rem;
    logic [RY_W-1:0]   r_d, n_d;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [RY_W:0]     w_rem_sh;
    logic [RY_W:0]     w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_q[ROOT_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_d});
    assign w_diff   = w_rem_sh - {1'b0, r_d};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[ROOT_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[RY_W-1:0] : w_rem_sh[RY_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### rtl/core/ellipse_span_generator_core.sv
`timescale 1ns / 1ps
// Ellipse span generator: turns one filled-ellipse request into horizontal spans, top row first.
// Depends on esg_pkg, esg_mul, esg_sqrt and esg_div.
//
// One request is taken at a time; the input stalls until its last span is in the output
// register. After a request is accepted, rx*rx is formed first. Each row then runs through
// three bit-serial units in turn: a multiply of rx*rx by ry*ry-dy*dy, a square root and a
// division by ry; the row is stepped as its span is emitted. With both radii nonzero a
// request has 2*ry+1 rows (ry+1 in top-half mode); a zero radius skips the arithmetic units.
// The output register holds a span while the next row is computed, so a slow consumer only
// holds up the generator when it is still stalling once the next row is ready. Radii above
// MAX_RADIUS_X and MAX_RADIUS_Y are clamped.
module ellipse_span_generator_core
    import esg_pkg::*;
#(
    parameter int MAX_RADIUS_X = 63,
    parameter int MAX_RADIUS_Y = 31
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CX_W-1:0]         i_centre_x,
    input  logic [CY_W-1:0]         i_centre_y,
    input  logic [RX_W-1:0]         i_radius_x,
    input  logic [RY_W-1:0]         i_radius_y,
    input  logic                    i_func,
    input  logic                    i_fill_colour,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [XY_W-1:0]  o_span_x,
    output logic signed [XY_W-1:0]  o_span_y,
    output logic [LEN_W-1:0]        o_span_length,
    output logic                    o_span_colour,
    output logic                    o_last_span
);

    localparam int RX_LIM_I = (MAX_RADIUS_X > (2 ** RX_W) - 1) ? (2 ** RX_W) - 1 : MAX_RADIUS_X;
    localparam int RY_LIM_I = (MAX_RADIUS_Y > (2 ** RY_W) - 1) ? (2 ** RY_W) - 1 : MAX_RADIUS_Y;
    localparam logic [RX_W-1:0] RX_LIM = RX_W'(RX_LIM_I);
    localparam logic [RY_W-1:0] RY_LIM = RY_W'(RY_LIM_I);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RXSQ = 7'b0000010,
        S_PREP = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [CX_W-1:0]          r_cx, n_cx;
    logic [CY_W-1:0]          r_cy, n_cy;
    logic [RX_W-1:0]          r_rx, n_rx;
    logic [RY_W-1:0]          r_ry, n_ry;
    logic                     r_func, n_func;
    logic                     r_colour, n_colour;
    logic signed [DY_W-1:0]   r_dy, n_dy;
    logic [MUL_B_W-1:0]       r_diff, n_diff;
    logic [MUL_A_W-1:0]       r_rxsq, n_rxsq;
    logic [HW_W-1:0]          r_hw, n_hw;

    logic                     r_ovalid, n_ovalid;
    logic [XY_W-1:0]          r_span_x, n_span_x;
    logic [XY_W-1:0]          r_span_y, n_span_y;
    logic [LEN_W-1:0]         r_span_len, n_span_len;
    logic                     r_span_col, n_span_col;
    logic                     r_last, n_last;

    logic [RX_W-1:0]          w_rx_sat;
    logic [RY_W-1:0]          w_ry_sat;
    logic                     w_accept;
    logic [RY_W-1:0]          w_ady;
    logic                     w_last;
    logic                     w_load;

    logic                     w_mul_start, w_mul_done;
    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]        w_mul_prod;
    logic                     w_sqrt_start, w_sqrt_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_div_start, w_div_done;
    logic [ROOT_W-1:0]        w_quot;

    assign w_rx_sat = (i_radius_x > RX_LIM) ? RX_LIM : i_radius_x;
    assign w_ry_sat = (i_radius_y > RY_LIM) ? RY_LIM : i_radius_y;
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_ady    = r_dy[DY_W-1] ? RY_W'(-r_dy) : r_dy[RY_W-1:0];
    assign w_last   = r_func ? (r_dy == '0) : (r_dy == $signed({1'b0, r_ry}));
    assign w_load   = (r_state == S_EMIT) && (!r_ovalid || !i_out_stall);

    assign w_mul_start  = (w_accept && (w_rx_sat != '0) && (w_ry_sat != '0))
                          || (r_state == S_PREP);
    assign w_mul_a      = (r_state == S_IDLE) ? MUL_A_W'(w_rx_sat) : r_rxsq;
    assign w_mul_b      = (r_state == S_IDLE) ? MUL_B_W'(w_rx_sat) : r_diff;
    assign w_sqrt_start = (r_state == S_MUL) && w_mul_done;
    assign w_div_start  = (r_state == S_SQRT) && w_sqrt_done;

    esg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    esg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_mul_prod),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    esg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_root),
        .i_divisor  (r_ry),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state    = r_state;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_rx       = r_rx;
        n_ry       = r_ry;
        n_func     = r_func;
        n_colour   = r_colour;
        n_dy       = r_dy;
        n_diff     = r_diff;
        n_rxsq     = r_rxsq;
        n_hw       = r_hw;
        n_ovalid   = r_ovalid && i_out_stall;
        n_span_x   = r_span_x;
        n_span_y   = r_span_y;
        n_span_len = r_span_len;
        n_span_col = r_span_col;
        n_last     = r_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cx     = i_centre_x;
                    n_cy     = i_centre_y;
                    n_rx     = w_rx_sat;
                    n_ry     = w_ry_sat;
                    n_func   = i_func;
                    n_colour = i_fill_colour;
                    n_dy     = -$signed({1'b0, w_ry_sat});
                    n_diff   = '0;
                    n_hw     = w_rx_sat;
                    if (w_rx_sat == '0) begin
                        n_state = S_IDLE;
                    end else if (w_ry_sat == '0) begin
                        n_state = i_func ? S_IDLE : S_EMIT;
                    end else begin
                        n_state = S_RXSQ;
                    end
                end
            end
            S_RXSQ: begin
                if (w_mul_done) begin
                    n_rxsq  = w_mul_prod[MUL_A_W-1:0];
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_hw    = w_quot[HW_W-1:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_ovalid   = 1'b1;
                    n_span_x   = XY_W'({1'b0, r_cx}) - XY_W'(r_hw);
                    n_span_y   = XY_W'({1'b0, r_cy}) + XY_W'(r_dy);
                    n_span_len = {r_hw, 1'b1};
                    n_span_col = r_colour;
                    n_last     = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        if (r_dy[DY_W-1]) begin
                            n_diff = r_diff + MUL_B_W'({w_ady, 1'b0}) - MUL_B_W'(1);
                        end else begin
                            n_diff = r_diff - MUL_B_W'({w_ady, 1'b1});
                        end
                        n_dy    = r_dy + DY_W'(1);
                        n_state = S_PREP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_rx       <= n_rx;
        r_ry       <= n_ry;
        r_func     <= n_func;
        r_colour   <= n_colour;
        r_dy       <= n_dy;
        r_diff     <= n_diff;
        r_rxsq     <= n_rxsq;
        r_hw       <= n_hw;
        r_span_x   <= n_span_x;
        r_span_y   <= n_span_y;
        r_span_len <= n_span_len;
        r_span_col <= n_span_col;
        r_last     <= n_last;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_span_x      = $signed(r_span_x);
    assign o_span_y      = $signed(r_span_y);
    assign o_span_length = r_span_len;
    assign o_span_colour = r_span_col;
    assign o_last_span   = r_last;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_mul_done, w_sqrt_done, w_div_done}))
        else $error("more than one arithmetic unit finished in the same cycle");

    a_diff_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |->
            (r_diff == (({5'b0, r_ry} * {5'b0, r_ry}) - ({5'b0, w_ady} * {5'b0, w_ady}))))
        else $error("running ry*ry-dy*dy lost track of the row offset");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> (r_dy <= $signed({1'b0, r_ry})))
        else $error("row offset ran past the bottom of the ellipse");

    a_half_width_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_hw <= r_rx))
        else $error("half-width exceeds the horizontal radius");

endmodule

### dv/ellipse_span_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ellipse_span_generator_core: predicts the spans of each
// accepted ellipse request and checks every output transaction against them in order.
// Depends on esg_pkg and the ellipse_span_generator_core RTL.
module ellipse_span_generator_core_tb;
    import esg_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_REQS = 296;

    typedef struct {
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
        logic [RX_W-1:0] rx;
        logic [RY_W-1:0] ry;
        logic            func;
        logic            colour;
    } t_ellipse_req;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [LEN_W-1:0]       len;
        logic                   colour;
        logic                   last;
    } t_span;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CX_W-1:0] centre_x = '0;
    logic [CY_W-1:0] centre_y = '0;
    logic [RX_W-1:0] radius_x = '0;
    logic [RY_W-1:0] radius_y = '0;
    logic func = 1'b0;
    logic fill_colour = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [XY_W-1:0] span_x;
    logic signed [XY_W-1:0] span_y;
    logic [LEN_W-1:0] span_length;
    logic span_colour;
    logic last_span;

    t_ellipse_req pending_reqs[$];
    t_span expected_spans[$];
    t_ellipse_req cur_req;
    int err_count = 0;
    int in_gap = 0;
    int out_gap = 0;
    int quiet_count = 0;
    int cycle_count = 0;
    logic idle_on = 1'b1;
    logic quiet_tail = 1'b0;

    ellipse_span_generator_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_centre_x    (centre_x),
        .i_centre_y    (centre_y),
        .i_radius_x    (radius_x),
        .i_radius_y    (radius_y),
        .i_func        (func),
        .i_fill_colour (fill_colour),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_span_x      (span_x),
        .o_span_y      (span_y),
        .o_span_length (span_length),
        .o_span_colour (span_colour),
        .o_last_span   (last_span)
    );

    always #1 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int unsigned floor_sqrt(input int unsigned n);
        int unsigned root = 0;
        int unsigned trial;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic add_span(input int cx, input int row, input int hw, input logic colour,
                            input logic last);
        t_span s;
        int sx;
        int len;
        sx = cx - hw;
        len = 2 * hw + 1;
        s.x = sx[XY_W-1:0];
        s.y = row[XY_W-1:0];
        s.len = len[LEN_W-1:0];
        s.colour = colour;
        s.last = last;
        expected_spans.push_back(s);
    endtask

    task automatic predict_spans(input t_ellipse_req r);
        int unsigned rx;
        int unsigned ry;
        int unsigned ady;
        int unsigned prod;
        int dy_end;
        rx = int'(r.rx);
        ry = int'(r.ry);
        if (rx == 0)
            return;
        if (ry == 0) begin
            if (!r.func)
                add_span(int'(r.cx), int'(r.cy), int'(rx), r.colour, 1'b1);
            return;
        end
        dy_end = r.func ? 0 : int'(ry);
        for (int dy = -int'(ry); dy <= dy_end; dy++) begin
            ady = (dy < 0) ? -dy : dy;
            prod = rx * rx * (ry * ry - ady * ady);
            add_span(int'(r.cx), int'(r.cy) + dy, int'(floor_sqrt(prod) / ry), r.colour,
                     dy == dy_end);
        end
    endtask

    task automatic queue_req(input int cx, input int cy, input int rx, input int ry,
                             input logic f, input logic colour);
        t_ellipse_req r;
        r.cx = cx[CX_W-1:0];
        r.cy = cy[CY_W-1:0];
        r.rx = rx[RX_W-1:0];
        r.ry = ry[RY_W-1:0];
        r.func = f;
        r.colour = colour;
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predict_spans(cur_req);
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    centre_x <= cur_req.cx;
                    centre_y <= cur_req.cy;
                    radius_x <= cur_req.rx;
                    radius_y <= cur_req.ry;
                    func <= cur_req.func;
                    fill_colour <= cur_req.colour;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            quiet_tail <= (pending_reqs.size() < 25);
        end
    end

    // monitor
    always @(posedge clk) begin
        t_span want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_spans.size() == 0) begin
                flag_error($sformatf("unexpected span x=%0d y=%0d len=%0d",
                                     span_x, span_y, span_length));
            end else begin
                want = expected_spans.pop_front();
                if (span_x !== want.x)
                    flag_error($sformatf("span_x got %0d want %0d", span_x, want.x));
                if (span_y !== want.y)
                    flag_error($sformatf("span_y got %0d want %0d", span_y, want.y));
                if (span_length !== want.len)
                    flag_error($sformatf("span_length got %0d want %0d",
                                         span_length, want.len));
                if (span_colour !== want.colour)
                    flag_error($sformatf("span_colour got %0b want %0b",
                                         span_colour, want.colour));
                if (last_span !== want.last)
                    flag_error($sformatf("last_span got %0b want %0b", last_span, want.last));
            end
        end
        if (out_gap > 0) begin
            out_gap--;
            out_stall <= 1'b1;
        end else if (rst_n && idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog; also switch idling on and off in stretches
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count % 400 == 0)
            idle_on <= ($urandom_range(0, 3) != 0);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT) begin
            $display("ellipse_span_generator_core test failed");
            $finish;
        end
    end

    initial begin
        int rx;
        int ry;
        // zero radii in both modes
        queue_req(64, 32, 0, 10, 1'b0, 1'b1);
        queue_req(64, 32, 0, 10, 1'b1, 1'b0);
        queue_req(0, 0, 63, 0, 1'b0, 1'b1);
        queue_req(127, 63, 63, 0, 1'b1, 1'b1);
        queue_req(5, 7, 0, 0, 1'b0, 1'b0);
        // largest ellipses at the corners, spans running off the display
        queue_req(0, 0, 63, 31, 1'b0, 1'b1);
        queue_req(127, 63, 63, 31, 1'b1, 1'b0);
        queue_req(127, 63, 63, 31, 1'b0, 1'b0);
        queue_req(0, 0, 63, 31, 1'b1, 1'b1);
        // narrow and flat shapes
        queue_req(60, 30, 1, 1, 1'b0, 1'b1);
        queue_req(60, 30, 1, 1, 1'b1, 1'b0);
        queue_req(10, 20, 1, 31, 1'b0, 1'b1);
        queue_req(100, 40, 63, 1, 1'b0, 1'b0);
        queue_req(100, 40, 63, 1, 1'b1, 1'b1);
        for (int i = 0; i < RANDOM_REQS; i++) begin
            rx = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63);
            case ($urandom_range(0, 9))
                0:       ry = 0;
                1, 2:    ry = $urandom_range(0, 31);
                default: ry = $urandom_range(1, 8);
            endcase
            queue_req($urandom_range(0, 127), $urandom_range(0, 63), rx, ry,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_spans.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ellipse_span_generator_core test passed");
        else
            $display("ellipse_span_generator_core test failed");
        $finish;
    end

endmodule
